// ----- rtl/mmed_pkg.sv -----
// Shared constants, types and helper functions for the min/max envelope decimator.
// Depends on nothing; rtl/min_max_envelope_decimator.sv uses it by scoped names.
package mmed_pkg;

    // Sample width taken from the input word (low bits, two's complement)
    localparam int SAMPLE_BITS  = 16;
    localparam int SAMPLE_SHIFT = 16 - SAMPLE_BITS;

    // Field and state widths
    localparam int COL_W  = 16;
    localparam int CNT_W  = 24;
    localparam int BND_W  = 40;
    localparam int Q_W    = 32;
    localparam int PROD_W = 48;
    localparam int SUM_W  = 49;
    localparam int CFG_IDX_W = 3;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_COLUMN_COUNT = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_COUNT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_X_ORIGIN     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_X_STEP       = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_Y_OFFSET     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_Y_GAIN       = 3'd5;

    typedef logic signed [Q_W-1:0]    coord_t;
    typedef logic signed [15:0]       smp_t;
    typedef logic signed [PROD_W-1:0] prod_t;
    typedef logic signed [SUM_W-1:0]  ysum_t;

    // Clamp a widened y sum to signed 32 bits
    function automatic coord_t sat_y(input ysum_t v);
        coord_t r;
        if (v[SUM_W-1:Q_W-1] == '0 || v[SUM_W-1:Q_W-1] == '1)
        begin
            r = v[Q_W-1:0];
        end
        else if (v[SUM_W-1])
        begin
            r = 32'sh8000_0000;
        end
        else
        begin
            r = 32'sh7FFF_FFFF;
        end
        return r;
    endfunction

    // Absolute difference of two Q16.16 values
    function automatic logic [Q_W:0] abs_diff(input coord_t a, input coord_t b);
        logic signed [Q_W:0] d;
        d = (Q_W+1)'(a) - (Q_W+1)'(b);
        return d[Q_W] ? (Q_W+1)'(-d) : (Q_W+1)'(d);
    endfunction

endpackage

// ----- rtl/min_max_envelope_decimator.sv -----
// Min/max envelope decimator: scope samples in, Q16.16 screen vertices out.
// An accepted input word is registered in stages A, B and C and then in the output buffer.
// Throughput: one input word per cycle when not stalled; one output word per cycle while
// m_axis_tready is high, so a column end (two vertices, single master port) takes two words.
// Reset (rst_n, asynchronous, active low) loads the register reset values, empties
// the pipeline and starts a new frame; any register write also restarts the frame.
// Depends on rtl/mmed_pkg.sv.
module min_max_envelope_decimator
(
    input  logic        clk,
    input  logic        rst_n,
    // configuration write port
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_data,
    // sample stream in
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // [15:0] sample
    // vertex stream out
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [63:0] m_axis_tdata,   // [31:0] x_pos, [63:32] y_pos
    output logic        m_axis_tlast,   // last_of_run
    output logic [1:0]  m_axis_tuser    // [0] envelope_mode, [1] frame_end
);

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [mmed_pkg::COL_W-1:0] column_count_reg;
    logic [mmed_pkg::CNT_W-1:0] sample_count_reg;
    mmed_pkg::coord_t           x_origin_reg;
    logic [mmed_pkg::Q_W-1:0]   x_step_reg;
    mmed_pkg::coord_t           y_offset_reg;
    mmed_pkg::coord_t           y_gain_reg;
    logic                       cfg_hit;

    // Frame state
    logic [mmed_pkg::CNT_W-1:0] idx_reg;
    logic [mmed_pkg::BND_W-1:0] bp_reg;
    logic [mmed_pkg::BND_W-1:0] thr_reg;
    logic [mmed_pkg::COL_W-1:0] col_reg;
    logic                       hp_reg;
    logic                       open_reg;
    mmed_pkg::smp_t             rmin_reg;
    mmed_pkg::smp_t             rmax_reg;
    logic [mmed_pkg::Q_W-1:0]   xacc_reg;

    // Front stage decode
    logic [15:0]                samp_shl;
    mmed_pkg::smp_t             s_val;
    logic                       s_fire;
    logic                       cnt_zero;
    logic                       start;
    logic [mmed_pkg::COL_W-1:0] cols;
    logic                       last;
    logic                       interp;
    logic [mmed_pkg::BND_W-1:0] bp_eff;
    logic [mmed_pkg::BND_W-1:0] thr_eff;
    logic [mmed_pkg::COL_W-1:0] col_eff;
    logic                       hp_eff;
    logic                       open_eff;
    logic [mmed_pkg::Q_W-1:0]   xacc_eff;
    logic [mmed_pkg::BND_W-1:0] bp_next;
    logic [mmed_pkg::BND_W:0]   bp_look;
    logic                       close;
    logic                       a_emit;
    mmed_pkg::smp_t             rmin_next;
    mmed_pkg::smp_t             rmax_next;
    logic [mmed_pkg::Q_W-1:0]   a_x_next;

    // Pipeline stage A: captured vertex request
    logic                       a_valid_reg;
    logic [mmed_pkg::Q_W-1:0]   a_x_reg;
    mmed_pkg::smp_t             a_smax_reg;
    mmed_pkg::smp_t             a_smin_reg;
    logic                       a_env_reg;
    logic                       a_fe_reg;
    logic                       a_first_reg;

    // Pipeline stage B: products
    logic                       b_valid_reg;
    logic [mmed_pkg::Q_W-1:0]   b_x_reg;
    mmed_pkg::prod_t            b_pmax_reg;
    mmed_pkg::prod_t            b_pmin_reg;
    mmed_pkg::prod_t            b_pmax_next;
    mmed_pkg::prod_t            b_pmin_next;
    logic                       b_env_reg;
    logic                       b_fe_reg;
    logic                       b_first_reg;

    // Pipeline stage C: saturated y values
    logic                       c_valid_reg;
    logic [mmed_pkg::Q_W-1:0]   c_x_reg;
    mmed_pkg::coord_t           c_ymax_reg;
    mmed_pkg::coord_t           c_ymin_reg;
    mmed_pkg::coord_t           c_ymax_next;
    mmed_pkg::coord_t           c_ymin_next;
    logic                       c_env_reg;
    logic                       c_fe_reg;
    logic                       c_first_reg;

    // Output buffer: one or two vertices
    logic                       o_valid_reg;
    logic                       o_sel_reg;
    logic [mmed_pkg::Q_W-1:0]   o_x_reg;
    mmed_pkg::coord_t           o_y0_reg;
    mmed_pkg::coord_t           o_y1_reg;
    logic                       o_env_reg;
    logic                       o_fe_reg;
    mmed_pkg::coord_t           prev_reg;
    logic                       top_first;
    mmed_pkg::coord_t           o_y0_next;
    mmed_pkg::coord_t           o_y1_next;

    // Flow control
    logic                       a_free;
    logic                       b_free;
    logic                       c_free;
    logic                       o_free;
    logic                       o_lastword;
    logic                       m_fire;
    logic                       o_load;

    // ------------------------------------------------------------------
    // Handshake chain
    // ------------------------------------------------------------------
    assign o_lastword    = !o_env_reg || o_sel_reg;
    assign m_fire        = o_valid_reg && m_axis_tready;
    assign o_free        = !o_valid_reg || (m_axis_tready && o_lastword);
    assign c_free        = !c_valid_reg || o_free;
    assign b_free        = !b_valid_reg || c_free;
    assign a_free        = !a_valid_reg || b_free;
    assign o_load        = c_valid_reg && o_free;
    assign s_axis_tready = a_free;
    assign s_fire        = s_axis_tvalid && a_free;

    // ------------------------------------------------------------------
    // Configuration writes
    // ------------------------------------------------------------------
    always_comb
    begin
        unique case (cfg_index) inside
            mmed_pkg::REG_COLUMN_COUNT,
            mmed_pkg::REG_SAMPLE_COUNT,
            mmed_pkg::REG_X_ORIGIN,
            mmed_pkg::REG_X_STEP,
            mmed_pkg::REG_Y_OFFSET,
            mmed_pkg::REG_Y_GAIN:     cfg_hit = cfg_we;
            default:                  cfg_hit = 1'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            column_count_reg <= 16'd1;
            sample_count_reg <= '0;
            x_origin_reg     <= '0;
            x_step_reg       <= '0;
            y_offset_reg     <= '0;
            y_gain_reg       <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                mmed_pkg::REG_COLUMN_COUNT: column_count_reg <= cfg_data[15:0];
                mmed_pkg::REG_SAMPLE_COUNT: sample_count_reg <= cfg_data[23:0];
                mmed_pkg::REG_X_ORIGIN:     x_origin_reg     <= cfg_data;
                mmed_pkg::REG_X_STEP:       x_step_reg       <= cfg_data;
                mmed_pkg::REG_Y_OFFSET:     y_offset_reg     <= cfg_data;
                mmed_pkg::REG_Y_GAIN:       y_gain_reg       <= cfg_data;
                default:                    ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Front stage: frame bookkeeping and column boundary test
    // ------------------------------------------------------------------
    assign samp_shl = s_axis_tdata << mmed_pkg::SAMPLE_SHIFT;
    assign s_val    = $signed(samp_shl) >>> mmed_pkg::SAMPLE_SHIFT;

    assign cnt_zero = (sample_count_reg == '0);
    assign start    = (idx_reg == '0);
    assign cols     = (column_count_reg == '0) ? 16'd1 : column_count_reg;
    assign last     = ({1'b0, idx_reg} + 25'd1) >= {1'b0, sample_count_reg};
    assign interp   = sample_count_reg <= {8'd0, cols};

    // Fresh frame values take over at the first sample of a frame
    assign bp_eff   = start ? '0 : bp_reg;
    assign thr_eff  = start ? {16'd0, sample_count_reg} : thr_reg;
    assign col_eff  = start ? '0 : col_reg;
    assign hp_eff   = start ? 1'b0 : hp_reg;
    assign open_eff = start ? 1'b0 : open_reg;
    assign xacc_eff = start ? x_origin_reg : xacc_reg;

    // Column closes when the next sample would cross the threshold, or at the frame's last sample
    assign bp_next  = bp_eff + {24'd0, cols};
    assign bp_look  = {1'b0, bp_next} + {25'd0, cols};
    assign close    = last || (bp_look > {1'b0, thr_eff});
    assign a_emit   = interp || close;

    // Track column extremes
    always_comb
    begin
        if (!open_eff)
        begin
            rmin_next = s_val;
            rmax_next = s_val;
        end
        else
        begin
            rmin_next = (s_val < rmin_reg) ? s_val : rmin_reg;
            rmax_next = (s_val > rmax_reg) ? s_val : rmax_reg;
        end
    end

    assign a_x_next = interp ? xacc_eff : (x_origin_reg + {col_eff, 16'h0000});

    // Advance frame state on each accepted word while the sample count is nonzero
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg  <= '0;
            bp_reg   <= '0;
            thr_reg  <= '0;
            col_reg  <= '0;
            hp_reg   <= 1'b0;
            open_reg <= 1'b0;
            rmin_reg <= '0;
            rmax_reg <= '0;
            xacc_reg <= '0;
        end
        else if (cfg_hit)
        begin
            idx_reg <= '0;
        end
        else if (s_fire && !cnt_zero)
        begin
            idx_reg <= last ? '0 : idx_reg + 24'd1;
            if (interp)
            begin
                bp_reg   <= bp_eff;
                thr_reg  <= thr_eff;
                col_reg  <= col_eff;
                hp_reg   <= hp_eff;
                open_reg <= open_eff;
                xacc_reg <= xacc_eff + x_step_reg;
            end
            else
            begin
                bp_reg   <= bp_next;
                xacc_reg <= xacc_eff;
                rmin_reg <= rmin_next;
                rmax_reg <= rmax_next;
                if (close)
                begin
                    open_reg <= 1'b0;
                    col_reg  <= col_eff + 16'd1;
                    thr_reg  <= thr_eff + {16'd0, sample_count_reg};
                    hp_reg   <= 1'b1;
                end
                else
                begin
                    open_reg <= 1'b1;
                    col_reg  <= col_eff;
                    thr_reg  <= thr_eff;
                    hp_reg   <= hp_eff;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage A register
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
        end
        else if (s_fire)
        begin
            a_valid_reg <= a_emit && !cnt_zero;
        end
        else if (b_free)
        begin
            a_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_fire && a_emit)
        begin
            a_x_reg     <= a_x_next;
            a_smax_reg  <= interp ? s_val : rmax_next;
            a_smin_reg  <= rmin_next;
            a_env_reg   <= !interp;
            a_fe_reg    <= last;
            a_first_reg <= !hp_eff;
        end
    end

    // ------------------------------------------------------------------
    // Stage B: scale by gain
    // ------------------------------------------------------------------
    assign b_pmax_next = mmed_pkg::prod_t'(y_gain_reg) * mmed_pkg::prod_t'(a_smax_reg);
    assign b_pmin_next = mmed_pkg::prod_t'(y_gain_reg) * mmed_pkg::prod_t'(a_smin_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_valid_reg <= 1'b0;
        end
        else if (b_free)
        begin
            b_valid_reg <= a_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (b_free && a_valid_reg)
        begin
            b_x_reg     <= a_x_reg;
            b_pmax_reg  <= b_pmax_next;
            b_pmin_reg  <= b_pmin_next;
            b_env_reg   <= a_env_reg;
            b_fe_reg    <= a_fe_reg;
            b_first_reg <= a_first_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage C: add offset and saturate
    // ------------------------------------------------------------------
    assign c_ymax_next = mmed_pkg::sat_y(mmed_pkg::ysum_t'(y_offset_reg)
                                         + mmed_pkg::ysum_t'(b_pmax_reg));
    assign c_ymin_next = mmed_pkg::sat_y(mmed_pkg::ysum_t'(y_offset_reg)
                                         + mmed_pkg::ysum_t'(b_pmin_reg));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            c_valid_reg <= 1'b0;
        end
        else if (c_free)
        begin
            c_valid_reg <= b_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (c_free && b_valid_reg)
        begin
            c_x_reg     <= b_x_reg;
            c_ymax_reg  <= c_ymax_next;
            c_ymin_reg  <= c_ymin_next;
            c_env_reg   <= b_env_reg;
            c_fe_reg    <= b_fe_reg;
            c_first_reg <= b_first_reg;
        end
    end

    // ------------------------------------------------------------------
    // Order the pair: vertex nearer the previous exit goes first
    // ------------------------------------------------------------------
    assign top_first = c_first_reg ||
                       (mmed_pkg::abs_diff(c_ymax_reg, prev_reg)
                        <= mmed_pkg::abs_diff(c_ymin_reg, prev_reg));
    assign o_y0_next = (!c_env_reg || top_first) ? c_ymax_reg : c_ymin_reg;
    assign o_y1_next = top_first ? c_ymin_reg : c_ymax_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            o_valid_reg <= 1'b0;
            o_sel_reg   <= 1'b0;
            prev_reg    <= '0;
        end
        else if (o_load)
        begin
            o_valid_reg <= 1'b1;
            o_sel_reg   <= 1'b0;
            if (c_env_reg)
            begin
                prev_reg <= o_y1_next;
            end
        end
        else if (m_fire)
        begin
            if (o_lastword)
            begin
                o_valid_reg <= 1'b0;
            end
            else
            begin
                o_sel_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (o_load)
        begin
            o_x_reg   <= c_x_reg;
            o_y0_reg  <= o_y0_next;
            o_y1_reg  <= o_y1_next;
            o_env_reg <= c_env_reg;
            o_fe_reg  <= c_fe_reg;
        end
    end

    // Drive the master port
    assign m_axis_tvalid = o_valid_reg;
    assign m_axis_tdata  = {(o_sel_reg ? o_y1_reg : o_y0_reg), o_x_reg};
    assign m_axis_tlast  = o_lastword;
    assign m_axis_tuser  = {o_fe_reg && o_lastword, o_env_reg};

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_second_only_in_pair: assert property (@(posedge clk) disable iff (!rst_n)
        o_valid_reg && o_sel_reg |-> o_env_reg)
        else $error("second vertex shown for a single-vertex word");

    a_zero_count_drops: assert property (@(posedge clk) disable iff (!rst_n)
        s_fire && cnt_zero |=> !a_valid_reg)
        else $error("word accepted with zero sample count produced output");

    a_index_in_frame: assert property (@(posedge clk) disable iff (!rst_n)
        idx_reg == '0 || idx_reg < sample_count_reg)
        else $error("sample index ran past the frame");

    a_pair_continues: assert property (@(posedge clk) disable iff (!rst_n)
        m_fire && !o_lastword |=> m_axis_tvalid && o_sel_reg)
        else $error("second vertex of a pair lost");

endmodule
